>>> hw/rtl/i2c_target_register_reader_defines.svh
// Assertion macros shared by the I2C target register reader RTL.
`ifndef I2C_TARGET_REGISTER_READER_DEFINES_SVH
`define I2C_TARGET_REGISTER_READER_DEFINES_SVH

// Check a same-cycle implication on the rising clock edge.
`define I2C_TRR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the following cycle.
`define I2C_TRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/i2c_trr_pkg.sv
// Types and constants of the I2C target register reader.
package i2c_trr_pkg;

  // Bus engine phases
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ADDR = 3'd1,
    PH_PTR  = 3'd2,
    PH_SEND = 3'd3,
    PH_HOLD = 3'd4
  } phase_e;

  // Item kinds
  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_WRITE  = 1'b1
  } cmd_e;

  // Bit counter landmarks in the address and pointer phases
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [3:0] BIT_ACK_LOW   = 4'd9;
  localparam logic [3:0] BIT_ACK_HIGH  = 4'd10;

  // Bank contents after reset
  localparam logic [7:0] INIT_IDX_A = 8'd1;
  localparam logic [7:0] INIT_VAL_A = 8'd161;
  localparam logic [7:0] INIT_IDX_B = 8'd2;
  localparam logic [7:0] INIT_VAL_B = 8'd123;

  typedef struct packed {
    cmd_e       command;
    logic       scl;
    logic       sda;
    logic [7:0] reg_index;
    logic [7:0] reg_value;
  } item_t;

  typedef struct packed {
    logic       sda_pull_low;
    logic       selected;
  } result_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } bank_wr_t;

  // Reset value of a bank entry
  function automatic logic [7:0] bank_init(input logic [7:0] idx);
    logic [7:0] val;
    val = 8'd0;
    if (idx == INIT_IDX_A) val = INIT_VAL_A;
    if (idx == INIT_IDX_B) val = INIT_VAL_B;
    return val;
  endfunction

endpackage

>>> hw/rtl/i2c_trr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module i2c_trr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/i2c_trr_bank.sv
// Register bank: RAM plus per-entry valid bits and a last-write bypass.
module i2c_trr_bank #(
  parameter int RegCount = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  i2c_trr_pkg::bank_wr_t wr_i,
  input  logic [7:0]           rd_addr_i,
  output logic [7:0]           rd_data_o
);

  localparam int AddrW = $clog2(RegCount);

  logic                we;
  logic [RegCount-1:0] valid_q;
  logic [7:0]          ram_rdata;
  logic                byp_v_q;
  logic [AddrW-1:0]    byp_addr_q;
  logic [7:0]          byp_data_q;

  // Drop writes beyond the bank
  assign we = wr_i.en && ({1'b0, wr_i.addr} < 9'(RegCount));

  i2c_trr_ram #(
    .Width (8),
    .Depth (RegCount)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_i.addr[AddrW-1:0]),
    .wdata_i (wr_i.data),
    .raddr_i (rd_addr_i[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Mark written entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we) begin
      valid_q[wr_i.addr[AddrW-1:0]] <= 1'b1;
    end
  end

  // Hold the last write, which the registered read does not yet show
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_v_q <= 1'b0;
    end else begin
      byp_v_q <= we;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_addr_q <= wr_i.addr[AddrW-1:0];
    byp_data_q <= wr_i.data;
  end

  // Select bypass, stored data or reset contents
  always_comb begin
    if (byp_v_q && (byp_addr_q == rd_addr_i[AddrW-1:0])) begin
      rd_data_o = byp_data_q;
    end else if (valid_q[rd_addr_i[AddrW-1:0]]) begin
      rd_data_o = ram_rdata;
    end else begin
      rd_data_o = i2c_trr_pkg::bank_init(rd_addr_i);
    end
  end

endmodule

>>> hw/rtl/i2c_trr_fsm.sv
// Bus engine: start/stop and clock edge detection, address, pointer and send phases.
module i2c_trr_fsm #(
  parameter int RegCount = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  i2c_trr_pkg::item_t   item_i,
  input  logic [6:0]           dev_addr_i,
  input  logic [7:0]           bank_data_i,
  output logic [7:0]           ptr_o,
  output i2c_trr_pkg::result_t result_o
);

  i2c_trr_pkg::phase_e phase_q, phase_d;
  logic [3:0] bc_q, bc_d;
  logic [7:0] sh_q, sh_d;
  logic       rm_q, rm_d;
  logic [7:0] ptr_q, ptr_d;
  logic       lscl_q, lscl_d;
  logic       lsda_q, lsda_d;

  // Next state
  always_comb begin
    logic [3:0] nbc;
    phase_d = phase_q;
    bc_d    = bc_q;
    sh_d    = sh_q;
    rm_d    = rm_q;
    ptr_d   = ptr_q;
    lscl_d  = lscl_q;
    lsda_d  = lsda_q;
    nbc     = (bc_q < i2c_trr_pkg::BITS_PER_BYTE) ? bc_q + 4'd1 : bc_q;
    if (step_i && (item_i.command == i2c_trr_pkg::CMD_SAMPLE)) begin
      if (lscl_q && item_i.scl) begin
        // Start or stop while the clock stays high
        if (lsda_q && !item_i.sda) begin
          phase_d = i2c_trr_pkg::PH_ADDR;
          bc_d    = 4'd0;
          sh_d    = 8'd0;
          rm_d    = 1'b0;
        end else if (!lsda_q && item_i.sda) begin
          phase_d = i2c_trr_pkg::PH_IDLE;
          bc_d    = 4'd0;
        end
      end else if (!lscl_q && item_i.scl) begin
        // Rising clock: shift in, or enter the ACK high period
        if (phase_q inside {i2c_trr_pkg::PH_ADDR, i2c_trr_pkg::PH_PTR}) begin
          if (bc_q < i2c_trr_pkg::BITS_PER_BYTE) begin
            sh_d = {sh_q[6:0], item_i.sda};
            bc_d = bc_q + 4'd1;
          end else if (bc_q == i2c_trr_pkg::BIT_ACK_LOW) begin
            bc_d = i2c_trr_pkg::BIT_ACK_HIGH;
          end
        end
      end else if (lscl_q && !item_i.scl) begin
        // Falling clock: advance the phase
        case (phase_q)
          i2c_trr_pkg::PH_SEND: begin
            if (bc_q < i2c_trr_pkg::BITS_PER_BYTE) begin
              sh_d = {sh_q[6:0], 1'b0};
            end
            if (nbc >= i2c_trr_pkg::BITS_PER_BYTE) begin
              phase_d = i2c_trr_pkg::PH_HOLD;
              bc_d    = 4'd0;
            end else begin
              bc_d = nbc;
            end
          end
          i2c_trr_pkg::PH_ADDR, i2c_trr_pkg::PH_PTR: begin
            if (bc_q == i2c_trr_pkg::BITS_PER_BYTE) begin
              if (phase_q == i2c_trr_pkg::PH_ADDR) begin
                if (sh_q[7:1] == dev_addr_i) begin
                  rm_d = sh_q[0];
                  bc_d = i2c_trr_pkg::BIT_ACK_LOW;
                end else begin
                  phase_d = i2c_trr_pkg::PH_IDLE;
                  bc_d    = 4'd0;
                end
              end else begin
                ptr_d = ({1'b0, sh_q} >= 9'(RegCount)) ? 8'd0 : sh_q;
                bc_d  = i2c_trr_pkg::BIT_ACK_LOW;
              end
            end else if (bc_q == i2c_trr_pkg::BIT_ACK_HIGH) begin
              bc_d = 4'd0;
              if (phase_q == i2c_trr_pkg::PH_ADDR) begin
                if (rm_q) begin
                  phase_d = i2c_trr_pkg::PH_SEND;
                  sh_d    = bank_data_i;
                end else begin
                  phase_d = i2c_trr_pkg::PH_PTR;
                  sh_d    = 8'd0;
                end
              end else begin
                phase_d = i2c_trr_pkg::PH_HOLD;
              end
            end
          end
          default: begin
          end
        endcase
      end
      lscl_d = item_i.scl;
      lsda_d = item_i.sda;
    end
  end

  // Outputs from the updated state
  always_comb begin
    result_o = '0;
    if ((phase_d inside {i2c_trr_pkg::PH_ADDR, i2c_trr_pkg::PH_PTR}) &&
        (bc_d inside {i2c_trr_pkg::BIT_ACK_LOW, i2c_trr_pkg::BIT_ACK_HIGH})) begin
      result_o.sda_pull_low = 1'b1;
    end
    if ((phase_d == i2c_trr_pkg::PH_SEND) && (bc_d < i2c_trr_pkg::BITS_PER_BYTE) &&
        !sh_d[7]) begin
      result_o.sda_pull_low = 1'b1;
    end
    if (((phase_d == i2c_trr_pkg::PH_ADDR) && (bc_d >= i2c_trr_pkg::BIT_ACK_LOW)) ||
        (phase_d inside {i2c_trr_pkg::PH_PTR, i2c_trr_pkg::PH_SEND,
                         i2c_trr_pkg::PH_HOLD})) begin
      result_o.selected = 1'b1;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= i2c_trr_pkg::PH_IDLE;
      bc_q    <= 4'd0;
      sh_q    <= 8'd0;
      rm_q    <= 1'b0;
      ptr_q   <= 8'd0;
      lscl_q  <= 1'b1;
      lsda_q  <= 1'b1;
    end else begin
      phase_q <= phase_d;
      bc_q    <= bc_d;
      sh_q    <= sh_d;
      rm_q    <= rm_d;
      ptr_q   <= ptr_d;
      lscl_q  <= lscl_d;
      lsda_q  <= lsda_d;
    end
  end

  assign ptr_o = ptr_q;

endmodule

>>> hw/rtl/i2c_target_register_reader.sv
// I2C target with a register bank, driven by line samples: top level.
// Usage:
//   The input channel carries one beat per line sample (command 0, scl, sda)
//   or per local bank write (command 1, reg_index, reg_value). Each accepted
//   beat yields exactly one result beat: sda_pull_low and selected, taken
//   from the target state after that beat.
//   The configuration channel writes the 7-bit bus address; it is always
//   ready and must only be used while no beat is in flight.
// Pipeline and throughput:
//   A beat is registered at the input register, then processed by the bus
//   engine once the result register is free or being read, which loads the
//   result register. One beat per cycle is sustained while out_ready_i is
//   high; the limit is the state update of the bus engine.
// Stall:
//   While the receiver holds out_ready_i low on a waiting result, it stays put
//   and at most one more beat enters the input register; then in_ready_o drops.
// Reset:
//   The engine goes idle with both sampled lines high, the address is 0,
//   and the bank reads its default contents at once (no clearing pass).
`include "i2c_target_register_reader_defines.svh"

module i2c_target_register_reader #(
  parameter int RegCount = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_device_address_i,
  // Input beats
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       command_i,
  input  logic       scl_i,
  input  logic       sda_i,
  input  logic [7:0] reg_index_i,
  input  logic [7:0] reg_value_i,
  // Result beats
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       sda_pull_low_o,
  output logic       selected_o
);

  logic                  s1_valid_q;
  i2c_trr_pkg::item_t    s1_item_q;
  logic                  out_valid_q;
  i2c_trr_pkg::result_t  out_res_q;
  i2c_trr_pkg::result_t  res;
  logic [6:0]            dev_addr_q;
  logic                  advance;
  logic [7:0]            ptr;
  logic [7:0]            bank_data;
  i2c_trr_pkg::bank_wr_t bank_wr;

  // Address register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= 7'd0;
    end else if (cfg_valid_i) begin
      dev_addr_q <= cfg_device_address_i;
    end
  end

  // Pipeline control
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input and result payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q.command   <= i2c_trr_pkg::cmd_e'(command_i);
      s1_item_q.scl       <= scl_i;
      s1_item_q.sda       <= sda_i;
      s1_item_q.reg_index <= reg_index_i;
      s1_item_q.reg_value <= reg_value_i;
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  // Local bank write
  always_comb begin
    bank_wr.en   = advance && (s1_item_q.command == i2c_trr_pkg::CMD_WRITE);
    bank_wr.addr = s1_item_q.reg_index;
    bank_wr.data = s1_item_q.reg_value;
  end

  i2c_trr_bank #(
    .RegCount (RegCount)
  ) u_bank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (bank_wr),
    .rd_addr_i (ptr),
    .rd_data_o (bank_data)
  );

  i2c_trr_fsm #(
    .RegCount (RegCount)
  ) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (s1_item_q),
    .dev_addr_i  (dev_addr_q),
    .bank_data_i (bank_data),
    .ptr_o       (ptr),
    .result_o    (res)
  );

  assign out_valid_o    = out_valid_q;
  assign sda_pull_low_o = out_res_q.sda_pull_low;
  assign selected_o     = out_res_q.selected;

  // Checks
  `I2C_TRR_ASSERT_NOW(a_pull_needs_sel, out_valid_q && out_res_q.sda_pull_low,
                      out_res_q.selected, "data line pulled low while not selected")
  `I2C_TRR_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_q,
                       "processed beat did not reach the result register")
  `I2C_TRR_ASSERT_NEXT(a_stall_keeps_input, s1_valid_q && out_valid_q && !out_ready_i,
                       s1_valid_q, "buffered beat lost during a stall")

endmodule

>>> dv/i2c_target_register_reader_test.sv
// Testbench for the I2C target register reader: bus sequences, local writes, scoreboard.
`timescale 1ns / 100ps

module i2c_target_register_reader_test;

  localparam int BankDepth = 16;
  localparam int BeatsPerPhase = 40;

  // Predicts the target's line drive and selection for every accepted beat
  class target_reply_scoreboard;
    logic [6:0]           dev_addr;
    i2c_trr_pkg::phase_e  ph;
    logic [3:0]           bit_cnt;
    logic [7:0]           shreg;
    logic                 rd_mode;
    logic [7:0]           ptr;
    logic [7:0]           bank[];
    logic                 prev_scl;
    logic                 prev_sda;
    i2c_trr_pkg::result_t pending_replies[$];
    int                   mismatches;

    function new(int depth);
      bank = new[depth];
      foreach (bank[i]) bank[i] = 8'd0;
      bank[i2c_trr_pkg::INIT_IDX_A] = i2c_trr_pkg::INIT_VAL_A;
      bank[i2c_trr_pkg::INIT_IDX_B] = i2c_trr_pkg::INIT_VAL_B;
      dev_addr   = 7'd0;
      ph         = i2c_trr_pkg::PH_IDLE;
      bit_cnt    = 4'd0;
      shreg      = 8'd0;
      rd_mode    = 1'b0;
      ptr        = 8'd0;
      prev_scl   = 1'b1;
      prev_sda   = 1'b1;
      mismatches = 0;
    endfunction

    // Shift a received bit, or move the ACK slot to its high half
    function void clock_rise(logic sda);
      if (ph != i2c_trr_pkg::PH_ADDR && ph != i2c_trr_pkg::PH_PTR) return;
      if (bit_cnt < i2c_trr_pkg::BITS_PER_BYTE) begin
        shreg   = {shreg[6:0], sda};
        bit_cnt = bit_cnt + 4'd1;
      end else if (bit_cnt == i2c_trr_pkg::BIT_ACK_LOW) begin
        bit_cnt = i2c_trr_pkg::BIT_ACK_HIGH;
      end
    endfunction

    // Advance the send shifter, decode the address or pointer, leave the ACK slot
    function void clock_fall();
      if (ph == i2c_trr_pkg::PH_SEND) begin
        if (bit_cnt < i2c_trr_pkg::BITS_PER_BYTE) begin
          shreg   = shreg << 1;
          bit_cnt = bit_cnt + 4'd1;
        end
        if (bit_cnt >= i2c_trr_pkg::BITS_PER_BYTE) begin
          ph      = i2c_trr_pkg::PH_HOLD;
          bit_cnt = 4'd0;
        end
      end else if (ph == i2c_trr_pkg::PH_ADDR || ph == i2c_trr_pkg::PH_PTR) begin
        if (bit_cnt == i2c_trr_pkg::BITS_PER_BYTE) begin
          if (ph == i2c_trr_pkg::PH_ADDR) begin
            if (shreg[7:1] == dev_addr) begin
              rd_mode = shreg[0];
              bit_cnt = i2c_trr_pkg::BIT_ACK_LOW;
            end else begin
              ph      = i2c_trr_pkg::PH_IDLE;
              bit_cnt = 4'd0;
            end
          end else begin
            ptr     = (shreg >= bank.size()) ? 8'd0 : shreg;
            bit_cnt = i2c_trr_pkg::BIT_ACK_LOW;
          end
        end else if (bit_cnt == i2c_trr_pkg::BIT_ACK_HIGH) begin
          bit_cnt = 4'd0;
          if (ph == i2c_trr_pkg::PH_PTR) begin
            ph = i2c_trr_pkg::PH_HOLD;
          end else if (rd_mode) begin
            ph    = i2c_trr_pkg::PH_SEND;
            shreg = (ptr < bank.size()) ? bank[ptr] : 8'd0;
          end else begin
            ph    = i2c_trr_pkg::PH_PTR;
            shreg = 8'd0;
          end
        end
      end
    endfunction

    // Update state from an accepted input beat and queue the reply it causes
    function void note_beat(i2c_trr_pkg::item_t it);
      i2c_trr_pkg::result_t r;
      if (it.command == i2c_trr_pkg::CMD_WRITE) begin
        if (it.reg_index < bank.size()) bank[it.reg_index] = it.reg_value;
      end else begin
        if (prev_scl && it.scl) begin
          if (prev_sda && !it.sda) begin
            ph      = i2c_trr_pkg::PH_ADDR;
            bit_cnt = 4'd0;
            shreg   = 8'd0;
            rd_mode = 1'b0;
          end else if (!prev_sda && it.sda) begin
            ph      = i2c_trr_pkg::PH_IDLE;
            bit_cnt = 4'd0;
          end
        end else if (!prev_scl && it.scl) begin
          clock_rise(it.sda);
        end else if (prev_scl && !it.scl) begin
          clock_fall();
        end
        prev_scl = it.scl;
        prev_sda = it.sda;
      end
      r.sda_pull_low = ((ph == i2c_trr_pkg::PH_ADDR || ph == i2c_trr_pkg::PH_PTR) &&
                        (bit_cnt == i2c_trr_pkg::BIT_ACK_LOW ||
                         bit_cnt == i2c_trr_pkg::BIT_ACK_HIGH)) ||
                       (ph == i2c_trr_pkg::PH_SEND &&
                        bit_cnt < i2c_trr_pkg::BITS_PER_BYTE && !shreg[7]);
      r.selected = (ph == i2c_trr_pkg::PH_ADDR && bit_cnt >= i2c_trr_pkg::BIT_ACK_LOW) ||
                   ph == i2c_trr_pkg::PH_PTR || ph == i2c_trr_pkg::PH_SEND ||
                   ph == i2c_trr_pkg::PH_HOLD;
      pending_replies.push_back(r);
    endfunction

    // Compare a result beat against the oldest predicted reply
    function void check_beat(i2c_trr_pkg::result_t got);
      i2c_trr_pkg::result_t want;
      if (pending_replies.size() == 0) begin
        $display("%0t: result beat with no reply pending (sda_pull_low %0b, selected %0b)",
                 $time, got.sda_pull_low, got.selected);
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      if (got.sda_pull_low !== want.sda_pull_low) begin
        $display("%0t: sda_pull_low expected %0b, actual %0b",
                 $time, want.sda_pull_low, got.sda_pull_low);
        mismatches++;
      end
      if (got.selected !== want.selected) begin
        $display("%0t: selected expected %0b, actual %0b",
                 $time, want.selected, got.selected);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [6:0] cfg_device_address_i = 7'd0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic       command_i = 1'b0;
  logic       scl_i = 1'b1;
  logic       sda_i = 1'b1;
  logic [7:0] reg_index_i = 8'd0;
  logic [7:0] reg_value_i = 8'd0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       sda_pull_low_o;
  logic       selected_o;

  target_reply_scoreboard sb;

  // Sender pacing and the bus levels last driven
  int   burst_left = 0;
  int   bus_beats = 0;
  logic cur_scl = 1'b1;
  logic cur_sda = 1'b1;

  // Receiver stall pattern
  int         stall_tick = 0;
  int         stall_mode = 0;
  logic [7:0] stall_pat = 8'h5A;

  i2c_target_register_reader #(
    .RegCount(BankDepth)
  ) u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_device_address_i(cfg_device_address_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .command_i           (command_i),
    .scl_i               (scl_i),
    .sda_i               (sda_i),
    .reg_index_i         (reg_index_i),
    .reg_value_i         (reg_value_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .sda_pull_low_o      (sda_pull_low_o),
    .selected_o          (selected_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watch both channels at each rising edge
  always @(posedge clk_i) begin : watch_beats
    i2c_trr_pkg::item_t   in_beat;
    i2c_trr_pkg::result_t out_beat;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        in_beat.command   = i2c_trr_pkg::cmd_e'(command_i);
        in_beat.scl       = scl_i;
        in_beat.sda       = sda_i;
        in_beat.reg_index = reg_index_i;
        in_beat.reg_value = reg_value_i;
        sb.note_beat(in_beat);
      end
      if (out_valid_o && out_ready_i) begin
        out_beat.sda_pull_low = sda_pull_low_o;
        out_beat.selected     = selected_o;
        sb.check_beat(out_beat);
      end
    end
  end

  // Stall the result channel: always ready, coin flips, or a rotating pattern
  always @(posedge clk_i) begin
    if (stall_tick == 0) begin
      stall_tick = $urandom_range(20, 80);
      stall_mode = $urandom_range(0, 2);
      stall_pat  = 8'($urandom);
      if (stall_pat == 8'd0) stall_pat = 8'h5A;
    end
    stall_tick--;
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      default: begin
        out_ready_i <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[7:1]};
      end
    endcase
  end

  // Present one input beat, opening a new burst, mostly after a gap, when the last one ran out
  task automatic put_beat(input i2c_trr_pkg::cmd_e cmd, input logic scl, input logic sda,
                          input logic [7:0] idx, input logic [7:0] val);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    scl_i       <= scl;
    sda_i       <= sda;
    reg_index_i <= idx;
    reg_value_i <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
  endtask

  // Store a byte in the bank from the local side
  task automatic local_write(input logic [7:0] idx, input logic [7:0] val);
    put_beat(i2c_trr_pkg::CMD_WRITE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
             idx, val);
  endtask

  // Drive one line sample, now and then preceded by a random local write
  task automatic drive_lines(input logic scl, input logic sda);
    logic [7:0] idx;
    if ($urandom_range(0, 15) == 0) begin
      idx = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, BankDepth - 1));
      local_write(idx, 8'($urandom));
    end
    put_beat(i2c_trr_pkg::CMD_SAMPLE, scl, sda, 8'($urandom), 8'($urandom));
    cur_scl = scl;
    cur_sda = sda;
    bus_beats++;
  endtask

  // Hold a level for one or two samples
  task automatic stretch(input logic scl, input logic sda);
    repeat ($urandom_range(1, 2)) drive_lines(scl, sda);
  endtask

  // One SCL pulse with SDA settled while the clock is low
  task automatic clock_bit(input logic b);
    if (cur_scl) drive_lines(1'b0, cur_sda);
    stretch(1'b0, b);
    stretch(1'b1, b);
    drive_lines(1'b0, b);
  endtask

  task automatic send_start();
    if (!(cur_scl && cur_sda)) begin
      if (cur_scl) drive_lines(1'b0, cur_sda);
      drive_lines(1'b0, 1'b1);
      drive_lines(1'b1, 1'b1);
    end
    drive_lines(1'b1, 1'b0);
    drive_lines(1'b0, 1'b0);
  endtask

  task automatic send_stop();
    if (cur_scl) drive_lines(1'b0, cur_sda);
    drive_lines(1'b0, 1'b0);
    drive_lines(1'b1, 1'b0);
    drive_lines(1'b1, 1'b1);
  endtask

  task automatic send_byte(input logic [7:0] b);
    for (int i = 7; i >= 0; i--) clock_bit(b[i]);
  endtask

  // Clock of the acknowledge bit; the line level there is ignored by the target
  task automatic ack_clock();
    clock_bit(1'($urandom_range(0, 1)));
  endtask

  // Address with write direction, pointer byte, then bytes the target ignores
  task automatic write_transfer(input logic [6:0] addr, input logic [7:0] pointer,
                                input int extra);
    send_start();
    send_byte({addr, 1'b0});
    ack_clock();
    send_byte(pointer);
    ack_clock();
    repeat (extra) begin
      send_byte(8'($urandom));
      ack_clock();
    end
  endtask

  // Address with read direction, then clock out whole bytes
  task automatic read_transfer(input logic [6:0] addr, input int nbytes);
    send_start();
    send_byte({addr, 1'b1});
    ack_clock();
    repeat (nbytes) begin
      repeat (8) clock_bit(1'($urandom_range(0, 1)));
      ack_clock();
    end
  endtask

  function automatic logic [6:0] pick_address();
    return ($urandom_range(0, 4) == 0) ? 7'($urandom) : sb.dev_addr;
  endfunction

  function automatic logic [7:0] pick_pointer();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, BankDepth - 1));
    return ($urandom_range(0, 1) == 0) ? 8'hFF : 8'($urandom_range(BankDepth, 255));
  endfunction

  // Mostly well-formed transfers; some noise and some aborted ones
  task automatic random_transfer();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(3, 12)) begin
        drive_lines(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end else if (kind < 55) begin
      write_transfer(pick_address(), pick_pointer(), $urandom_range(0, 1));
    end else if (kind < 90) begin
      read_transfer(pick_address(), $urandom_range(1, 2));
    end else begin
      send_start();
      repeat ($urandom_range(1, 16)) clock_bit(1'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 9) < 7) send_stop();
  endtask

  // Drop valid and let every predicted reply arrive
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_device_address(input logic [6:0] addr);
    cfg_valid_i          <= 1'b1;
    cfg_device_address_i <= addr;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.dev_addr = addr;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [6:0] phase_addr[3];
    sb = new(BankDepth);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bank edges, pointer bound, mismatch, repeated start, coincident edges
    set_device_address(7'h00);
    local_write(8'd0, 8'hFF);
    local_write(8'd15, 8'h00);
    local_write(8'd16, 8'hAA);
    local_write(8'hFF, 8'h55);
    write_transfer(7'h00, 8'd200, 0);
    read_transfer(7'h00, 1);
    send_stop();
    send_start();
    send_byte({7'h7F, 1'b0});
    ack_clock();
    send_stop();
    send_start();
    drive_lines(1'b1, 1'b1);
    drive_lines(1'b0, 1'b0);
    drive_lines(1'b1, 1'b1);
    drive_lines(1'b0, 1'b0);
    send_stop();
    write_transfer(7'h00, 8'd15, 0);
    read_transfer(7'h00, 1);
    send_stop();
    drain();

    // Random phases, each under its own bus address
    phase_addr[0] = 7'h7F;
    phase_addr[1] = 7'($urandom);
    phase_addr[2] = 7'h00;
    foreach (phase_addr[p]) begin
      set_device_address(phase_addr[p]);
      bus_beats = 0;
      while (bus_beats < BeatsPerPhase) random_transfer();
      send_stop();
      drain();
    end

    if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
      $display("i2c_target_register_reader test passed");
    end else begin
      $display("i2c_target_register_reader test failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("i2c_target_register_reader test failed");
    $finish;
  end

endmodule
